FILE: rtl/pca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair collision package
// Widths, item and job types, and the saturation helpers used by the
// back end.
// ----------------------------------------------------------------------------
package pca_pkg;

    localparam int POS_W  = 32;   // signed Q16.16 position or acceleration
    localparam int RAD_W  = 31;   // unsigned radius
    localparam int MASS_W = 31;   // unsigned mass
    localparam int G_W    = 32;   // unsigned coefficient
    localparam int DC_W   = 33;   // magnitude of a coordinate difference
    localparam int SQ_W   = 66;   // square and sum of squares
    localparam int ROOT_W = 34;   // distance
    localparam int OV_W   = 32;   // overlap depth and radius sum
    localparam int GM_W   = 63;   // coefficient times mass
    localparam int PN_W   = 65;   // push numerator
    localparam int PD_W   = 35;   // push divisor
    localparam int PL_W   = 65;   // low partial product
    localparam int PH_W   = 64;   // high partial product
    localparam int AN_W   = 96;   // attraction numerator
    localparam int AD_W   = 68;   // attraction divisor (distance squared)
    localparam int Q_W    = 34;   // quotient bits of each divider
    localparam int EXT_W  = 36;   // widened position sum

    localparam logic [G_W-1:0]   G_RESET = 32'h0001_0000;
    localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] NEG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [POS_W-1:0]  x1;
        logic [POS_W-1:0]  y1;
        logic [POS_W-1:0]  x2;
        logic [POS_W-1:0]  y2;
        logic [RAD_W-1:0]  r1;
        logic [RAD_W-1:0]  r2;
        logic [MASS_W-1:0] m1;
        logic [MASS_W-1:0] m2;
        logic              mov1;
        logic              mov2;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0]  x1;
        logic [POS_W-1:0]  y1;
        logic [POS_W-1:0]  x2;
        logic [POS_W-1:0]  y2;
        logic              sdx;
        logic              sdy;
        logic [DC_W-1:0]   adx;
        logic [DC_W-1:0]   ady;
        logic [OV_W-1:0]   rsum;
        logic [MASS_W-1:0] m1;
        logic [MASS_W-1:0] m2;
        logic              mov1;
        logic              mov2;
        logic              coin;
    } t_fpay;

    typedef struct packed {
        t_fpay             pay;
        logic [ROOT_W-1:0] distance;
        logic              ovl;
        logic [OV_W-1:0]   ov;
    } t_job;

    typedef struct packed {
        logic [POS_W-1:0] x1;
        logic [POS_W-1:0] y1;
        logic [POS_W-1:0] x2;
        logic [POS_W-1:0] y2;
        logic             sdx;
        logic             sdy;
        logic             ovl;
        logic             coin;
        logic             mov1;
        logic             mov2;
    } t_bpay;

    typedef struct packed {
        logic [POS_W-1:0] n1x;
        logic [POS_W-1:0] n1y;
        logic [POS_W-1:0] n2x;
        logic [POS_W-1:0] n2y;
        logic [POS_W-1:0] a1x;
        logic [POS_W-1:0] a1y;
        logic [POS_W-1:0] a2x;
        logic [POS_W-1:0] a2y;
        logic             ovl;
        logic             coin;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Clamp a widened two's complement sum to 32 bits.
    function automatic logic [POS_W-1:0] sat_pos(input logic [EXT_W-1:0] v);
        logic ovp;
        logic ovn;
        ovp = !v[EXT_W-1] && (v[EXT_W-2:POS_W-1] != '0);
        ovn = v[EXT_W-1] && (v[EXT_W-2:POS_W-1] != '1);
        priority if (ovp) begin
            return POS_MAX;
        end else if (ovn) begin
            return NEG_MIN;
        end else begin
            return v[POS_W-1:0];
        end
    endfunction

    // Apply the sign to an attraction quotient, clamping the magnitude.
    function automatic logic [POS_W-1:0] attract_val(input logic [Q_W-1:0] q,
                                                     input logic ovf,
                                                     input logic negative);
        logic [POS_W-1:0] cap;
        logic [POS_W-1:0] mag;
        cap = negative ? NEG_MIN : POS_MAX;
        mag = (ovf || (q > Q_W'(cap))) ? cap : q[POS_W-1:0];
        return negative ? (POS_W'(0) - mag) : mag;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pca_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, restoring method, with a side payload and a
// valid bit carried alongside.
// ----------------------------------------------------------------------------
module pca_sqrt #(
    parameter int RW = 34,
    parameter int PW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*RW-1:0] i_rad,
    input  wire logic [PW-1:0]   i_pay,
    output logic                 o_valid,
    output logic [RW-1:0]        o_root,
    output logic [PW-1:0]        o_pay
);
    localparam int SW   = 2 * RW;
    localparam int REMW = RW + 2;

    logic [REMW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [SW-1:0]   r_rad  [RW];
    logic [PW-1:0]   r_pay  [RW];
    logic            r_vld  [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic [REMW-1:0] rem_in;
            logic [RW-1:0]   root_in;
            logic [SW-1:0]   rad_in;
            logic [PW-1:0]   pay_in;
            logic            vld_in;
            logic [REMW+1:0] sh;
            logic [REMW+1:0] trial;
            logic            ge;

            if (k == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = i_rad;
                assign pay_in  = i_pay;
                assign vld_in  = i_valid;
            end else begin : g_next
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
                assign rad_in  = r_rad[k-1];
                assign pay_in  = r_pay[k-1];
                assign vld_in  = r_vld[k-1];
            end

            assign sh    = {rem_in, rad_in[SW-1:SW-2]};
            assign trial = (REMW + 2)'({root_in, 2'b01});
            assign ge    = (sh >= trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= ge ? REMW'(sh - trial) : REMW'(sh);
                    r_root[k] <= {root_in[RW-2:0], ge};
                    r_rad[k]  <= {rad_in[SW-3:0], 2'b00};
                    r_pay[k]  <= pay_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_pay   = r_pay[RW-1];

endmodule
`default_nettype wire

FILE: rtl/pca_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage after an overflow check; a quotient that does
// not fit in QW bits raises the overflow flag.
// ----------------------------------------------------------------------------
module pca_div #(
    parameter int NW = 65,
    parameter int DW = 35,
    parameter int QW = 34
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic [QW-1:0]      o_quo,
    output logic               o_ovf
);
    logic [DW-1:0] r0_rem;
    logic [QW-1:0] r0_low;
    logic [DW-1:0] r0_den;
    logic          r0_ovf;

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];
    logic          r_ovf [QW];

    // The upper numerator bits must already be below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_rem <= DW'(i_num[NW-1:QW]);
            r0_low <= i_num[QW-1:0];
            r0_den <= i_den;
            r0_ovf <= (DW'(i_num[NW-1:QW]) >= i_den);
        end
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] q_in;
            logic [DW-1:0] den_in;
            logic          ovf_in;
            logic [DW:0]   sh;
            logic          ge;

            if (k == 0) begin : g_first
                assign rem_in = r0_rem;
                assign low_in = r0_low;
                assign q_in   = '0;
                assign den_in = r0_den;
                assign ovf_in = r0_ovf;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign low_in = r_low[k-1];
                assign q_in   = r_q[k-1];
                assign den_in = r_den[k-1];
                assign ovf_in = r_ovf[k-1];
            end

            assign sh = {rem_in, low_in[QW-1]};
            assign ge = (sh >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? DW'(sh - {1'b0, den_in}) : DW'(sh);
                    r_low[k] <= {low_in[QW-2:0], 1'b0};
                    r_q[k]   <= {q_in[QW-2:0], ge};
                    r_den[k] <= den_in;
                    r_ovf[k] <= ovf_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_q[QW-1];
    assign o_ovf = r_ovf[QW-1];

endmodule
`default_nettype wire

FILE: rtl/pca_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Small register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module pca_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire logic [W-1:0] i_wdata,
    input  wire logic         i_rd,
    output logic [W-1:0]      o_rdata,
    output pca_pkg::t_fifo_stat o_stat
);
    import pca_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wp;
    logic [AW-1:0] n_rp;

    assign n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= n_wp;
            end
            if (i_rd) begin
                r_rp <= n_rp;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule
`default_nettype wire

FILE: rtl/pca_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair collision front end
// Takes pairs, forms the differences and the distance, and classifies the
// pair as coincident or overlapping before handing it to the queue.
// ----------------------------------------------------------------------------
module pca_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire pca_pkg::t_item      i_item,
    input  wire pca_pkg::t_fifo_stat i_stat,
    output logic                     o_stall,
    output logic                     o_wr,
    output pca_pkg::t_job            o_job
);
    import pca_pkg::*;

    localparam int PW = $bits(t_fpay);

    logic              en;
    logic [DC_W-1:0]   dx;
    logic [DC_W-1:0]   dy;
    t_fpay             a_next;
    logic              r_a_valid;
    t_fpay             r_a;
    logic              r_b_valid;
    t_fpay             r_b;
    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;
    logic [SQ_W-1:0]   sum_sq;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [PW-1:0]     sq_pay_v;
    t_fpay             sq_pay;

    // The whole front pipeline freezes only when a finished job meets a full queue.
    assign en      = !(sq_valid && i_stat.full);
    assign o_stall = !en;
    assign o_wr    = sq_valid && en;

    assign dx = {i_item.x2[POS_W-1], i_item.x2} - {i_item.x1[POS_W-1], i_item.x1};
    assign dy = {i_item.y2[POS_W-1], i_item.y2} - {i_item.y1[POS_W-1], i_item.y1};

    always_comb begin
        a_next.x1   = i_item.x1;
        a_next.y1   = i_item.y1;
        a_next.x2   = i_item.x2;
        a_next.y2   = i_item.y2;
        a_next.sdx  = dx[DC_W-1];
        a_next.sdy  = dy[DC_W-1];
        a_next.adx  = dx[DC_W-1] ? (~dx + 1'b1) : dx;
        a_next.ady  = dy[DC_W-1] ? (~dy + 1'b1) : dy;
        a_next.rsum = {1'b0, i_item.r1} + {1'b0, i_item.r2};
        a_next.m1   = i_item.m1;
        a_next.m2   = i_item.m2;
        a_next.mov1 = i_item.mov1;
        a_next.mov2 = i_item.mov2;
        a_next.coin = (dx == '0) && (dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a   <= a_next;
            r_b   <= r_a;
            r_sqx <= SQ_W'(r_a.adx) * SQ_W'(r_a.adx);
            r_sqy <= SQ_W'(r_a.ady) * SQ_W'(r_a.ady);
        end
    end

    assign sum_sq = r_sqx + r_sqy;

    pca_sqrt #(
        .RW (ROOT_W),
        .PW (PW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_rad   ((2 * ROOT_W)'(sum_sq)),
        .i_pay   (r_b),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_pay   (sq_pay_v)
    );

    assign sq_pay = t_fpay'(sq_pay_v);

    always_comb begin
        o_job.pay      = sq_pay;
        o_job.distance = sq_root;
        o_job.ovl      = !sq_pay.coin && (sq_root < ROOT_W'(sq_pay.rsum));
        o_job.ov       = sq_pay.rsum - sq_root[OV_W-1:0];
    end

endmodule
`default_nettype wire

FILE: rtl/pca_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair collision back end
// Pulls jobs from the queue, forms the push and attraction quotients and
// drives the result register.
// ----------------------------------------------------------------------------
module pca_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [31:0]         i_gcoef,
    input  wire pca_pkg::t_job       i_job,
    input  wire pca_pkg::t_fifo_stat i_stat,
    input  wire logic                i_stall,
    output logic                     o_pop,
    output logic                     o_valid,
    output pca_pkg::t_result         o_res
);
    import pca_pkg::*;

    localparam int LN = Q_W + 1;

    logic            en;
    logic            r_b1_valid;
    t_job            r_b1;

    logic            r_b2_valid;
    t_bpay           r_b2_pay;
    logic [GM_W-1:0] r_gm1;
    logic [GM_W-1:0] r_gm2;
    logic [PN_W-1:0] r_b2_px;
    logic [PN_W-1:0] r_b2_py;
    logic [AD_W-1:0] r_b2_dd;
    logic [PD_W-1:0] r_b2_pden;
    logic [DC_W-1:0] r_adx;
    logic [DC_W-1:0] r_ady;

    logic            r_b3_valid;
    t_bpay           r_b3_pay;
    logic [PN_W-1:0] r_b3_px;
    logic [PN_W-1:0] r_b3_py;
    logic [AD_W-1:0] r_b3_dd;
    logic [PD_W-1:0] r_b3_pden;
    logic [PL_W-1:0] r_l1x, r_l1y, r_l2x, r_l2y;
    logic [PH_W-1:0] r_h1x, r_h1y, r_h2x, r_h2y;

    logic [AN_W-1:0] n1x, n1y, n2x, n2y;
    logic [Q_W-1:0]  pqx, pqy, q1x, q1y, q2x, q2y;
    logic            povx, povy, ov1x, ov1y, ov2x, ov2y;

    t_bpay           r_ln     [LN];
    logic            r_ln_vld [LN];
    t_bpay           e;

    logic [Q_W-1:0]   pmx, pmy;
    logic [EXT_W-1:0] psx, psy;
    logic [POS_W-1:0] m1x, m1y, m2x, m2y;
    t_result          res_next;
    logic             r_out_valid;
    t_result          r_res;

    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && !i_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid <= !i_stat.empty;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1 <= i_job;

            r_b2_pay.x1   <= r_b1.pay.x1;
            r_b2_pay.y1   <= r_b1.pay.y1;
            r_b2_pay.x2   <= r_b1.pay.x2;
            r_b2_pay.y2   <= r_b1.pay.y2;
            r_b2_pay.sdx  <= r_b1.pay.sdx;
            r_b2_pay.sdy  <= r_b1.pay.sdy;
            r_b2_pay.ovl  <= r_b1.ovl;
            r_b2_pay.coin <= r_b1.pay.coin;
            r_b2_pay.mov1 <= r_b1.pay.mov1;
            r_b2_pay.mov2 <= r_b1.pay.mov2;
            r_gm1     <= GM_W'(i_gcoef) * GM_W'(r_b1.pay.m1);
            r_gm2     <= GM_W'(i_gcoef) * GM_W'(r_b1.pay.m2);
            r_b2_px   <= PN_W'(r_b1.pay.adx) * PN_W'(r_b1.ov);
            r_b2_py   <= PN_W'(r_b1.pay.ady) * PN_W'(r_b1.ov);
            r_b2_dd   <= AD_W'(r_b1.distance) * AD_W'(r_b1.distance);
            // Both particles share the push when both may move.
            r_b2_pden <= (r_b1.pay.mov1 && r_b1.pay.mov2) ? {r_b1.distance, 1'b0}
                                                          : {1'b0, r_b1.distance};
            r_adx     <= r_b1.pay.adx;
            r_ady     <= r_b1.pay.ady;

            r_b3_pay  <= r_b2_pay;
            r_b3_px   <= r_b2_px;
            r_b3_py   <= r_b2_py;
            r_b3_dd   <= r_b2_dd;
            r_b3_pden <= r_b2_pden;
            r_l1x <= PL_W'(r_gm2[31:0]) * PL_W'(r_adx);
            r_h1x <= PH_W'(r_gm2[GM_W-1:32]) * PH_W'(r_adx);
            r_l1y <= PL_W'(r_gm2[31:0]) * PL_W'(r_ady);
            r_h1y <= PH_W'(r_gm2[GM_W-1:32]) * PH_W'(r_ady);
            r_l2x <= PL_W'(r_gm1[31:0]) * PL_W'(r_adx);
            r_h2x <= PH_W'(r_gm1[GM_W-1:32]) * PH_W'(r_adx);
            r_l2y <= PL_W'(r_gm1[31:0]) * PL_W'(r_ady);
            r_h2y <= PH_W'(r_gm1[GM_W-1:32]) * PH_W'(r_ady);
        end
    end

    assign n1x = {r_h1x, 32'd0} + AN_W'(r_l1x);
    assign n1y = {r_h1y, 32'd0} + AN_W'(r_l1y);
    assign n2x = {r_h2x, 32'd0} + AN_W'(r_l2x);
    assign n2y = {r_h2y, 32'd0} + AN_W'(r_l2y);

    pca_div #(.NW(PN_W), .DW(PD_W), .QW(Q_W)) u_div_px (
        .i_clk(i_clk), .i_en(en), .i_num(r_b3_px), .i_den(r_b3_pden),
        .o_quo(pqx), .o_ovf(povx)
    );
    pca_div #(.NW(PN_W), .DW(PD_W), .QW(Q_W)) u_div_py (
        .i_clk(i_clk), .i_en(en), .i_num(r_b3_py), .i_den(r_b3_pden),
        .o_quo(pqy), .o_ovf(povy)
    );
    pca_div #(.NW(AN_W), .DW(AD_W), .QW(Q_W)) u_div_a1x (
        .i_clk(i_clk), .i_en(en), .i_num(n1x), .i_den(r_b3_dd),
        .o_quo(q1x), .o_ovf(ov1x)
    );
    pca_div #(.NW(AN_W), .DW(AD_W), .QW(Q_W)) u_div_a1y (
        .i_clk(i_clk), .i_en(en), .i_num(n1y), .i_den(r_b3_dd),
        .o_quo(q1y), .o_ovf(ov1y)
    );
    pca_div #(.NW(AN_W), .DW(AD_W), .QW(Q_W)) u_div_a2x (
        .i_clk(i_clk), .i_en(en), .i_num(n2x), .i_den(r_b3_dd),
        .o_quo(q2x), .o_ovf(ov2x)
    );
    pca_div #(.NW(AN_W), .DW(AD_W), .QW(Q_W)) u_div_a2y (
        .i_clk(i_clk), .i_en(en), .i_num(n2y), .i_den(r_b3_dd),
        .o_quo(q2y), .o_ovf(ov2y)
    );

    // Payload line matched to the divider latency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LN; i++) begin
                r_ln_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_ln_vld[0] <= r_b3_valid;
            for (int i = 1; i < LN; i++) begin
                r_ln_vld[i] <= r_ln_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ln[0] <= r_b3_pay;
            for (int i = 1; i < LN; i++) begin
                r_ln[i] <= r_ln[i-1];
            end
        end
    end

    assign e   = r_ln[LN-1];
    assign pmx = povx ? '1 : pqx;
    assign pmy = povy ? '1 : pqy;
    assign psx = e.sdx ? (EXT_W'(0) - EXT_W'(pmx)) : EXT_W'(pmx);
    assign psy = e.sdy ? (EXT_W'(0) - EXT_W'(pmy)) : EXT_W'(pmy);

    assign m1x = sat_pos({{(EXT_W-POS_W){e.x1[POS_W-1]}}, e.x1} - psx);
    assign m1y = sat_pos({{(EXT_W-POS_W){e.y1[POS_W-1]}}, e.y1} - psy);
    assign m2x = sat_pos({{(EXT_W-POS_W){e.x2[POS_W-1]}}, e.x2} + psx);
    assign m2y = sat_pos({{(EXT_W-POS_W){e.y2[POS_W-1]}}, e.y2} + psy);

    always_comb begin
        res_next.n1x  = e.x1;
        res_next.n1y  = e.y1;
        res_next.n2x  = e.x2;
        res_next.n2y  = e.y2;
        res_next.ovl  = e.ovl;
        res_next.coin = e.coin;
        if (e.ovl) begin
            priority if (!e.mov1) begin
                res_next.n2x = m2x;
                res_next.n2y = m2y;
            end else if (!e.mov2) begin
                res_next.n1x = m1x;
                res_next.n1y = m1y;
            end else begin
                res_next.n1x = m1x;
                res_next.n1y = m1y;
                res_next.n2x = m2x;
                res_next.n2y = m2y;
            end
        end
        if (e.coin) begin
            res_next.a1x = '0;
            res_next.a1y = '0;
            res_next.a2x = '0;
            res_next.a2y = '0;
        end else begin
            res_next.a1x = attract_val(q1x, ov1x, e.sdx);
            res_next.a1y = attract_val(q1y, ov1y, e.sdy);
            res_next.a2x = attract_val(q2x, ov2x, !e.sdx);
            res_next.a2y = attract_val(q2y, ov2y, !e.sdy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_ln_vld[LN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= res_next;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

FILE: rtl/pairwise_collision_attraction_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pairwise collision and attraction core
// Resolves circle overlap for one particle pair per transaction and forms the
// 1/r attraction deltas of both particles, in saturating Q16.16.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Contents
//  in        input      i_in_valid / o_in_stall  positions, radii, masses, flags
//  out       output     o_out_valid / i_out_stall new positions, accelerations, flags
//  cfg       input      i_cfg_we                 attraction coefficient G
//
// One transaction is accepted per cycle while o_in_stall is low, and one result
// leaves per cycle while i_out_stall is low. The latency from input to output
// is set by the 34-stage square root in the front end and the 35-stage dividers
// in the back end. Reset is synchronous and active low; it empties every
// pipeline and the queue and loads G with 1.0. A stall on the output freezes
// the back end only; the front end keeps accepting until the queue between
// them fills, and then raises o_in_stall.
//
module pairwise_collision_attraction_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic signed [31:0] i_first_x,
    input  wire logic signed [31:0] i_first_y,
    input  wire logic signed [31:0] i_second_x,
    input  wire logic signed [31:0] i_second_y,
    input  wire logic [30:0] i_first_radius,
    input  wire logic [30:0] i_second_radius,
    input  wire logic [30:0] i_first_mass,
    input  wire logic [30:0] i_second_mass,
    input  wire logic        i_first_movable,
    input  wire logic        i_second_movable,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [31:0] o_new_first_x,
    output logic signed [31:0] o_new_first_y,
    output logic signed [31:0] o_new_second_x,
    output logic signed [31:0] o_new_second_y,
    output logic signed [31:0] o_first_accel_dx,
    output logic signed [31:0] o_first_accel_dy,
    output logic signed [31:0] o_second_accel_dx,
    output logic signed [31:0] o_second_accel_dy,
    output logic             o_overlapped,
    output logic             o_coincident
);
    import pca_pkg::*;

    logic [G_W-1:0] r_gcoef;
    t_item          item;
    logic           fifo_wr;
    logic           fifo_rd;
    t_job           wjob;
    t_job           rjob;
    logic [$bits(t_job)-1:0] rjob_v;
    t_fifo_stat     fstat;
    t_result        res;

    // The user must write the coefficient only while the core is idle; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcoef <= G_RESET;
        end else if (i_cfg_we) begin
            r_gcoef <= i_cfg_data;
        end
    end

    always_comb begin
        item.x1   = i_first_x;
        item.y1   = i_first_y;
        item.x2   = i_second_x;
        item.y2   = i_second_y;
        item.r1   = i_first_radius;
        item.r2   = i_second_radius;
        item.m1   = i_first_mass;
        item.m2   = i_second_mass;
        item.mov1 = i_first_movable;
        item.mov2 = i_second_movable;
    end

    // Front end: differences, distance and classification.
    pca_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (item),
        .i_stat  (fstat),
        .o_stall (o_in_stall),
        .o_wr    (fifo_wr),
        .o_job   (wjob)
    );

    // Short queue that lets either side stall on its own.
    pca_fifo #(
        .W     ($bits(t_job)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .i_wdata (wjob),
        .i_rd    (fifo_rd),
        .o_rdata (rjob_v),
        .o_stat  (fstat)
    );

    assign rjob = t_job'(rjob_v);

    // Back end: push and attraction quotients, saturation, result register.
    pca_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gcoef (r_gcoef),
        .i_job   (rjob),
        .i_stat  (fstat),
        .i_stall (i_out_stall),
        .o_pop   (fifo_rd),
        .o_valid (o_out_valid),
        .o_res   (res)
    );

    assign o_new_first_x     = res.n1x;
    assign o_new_first_y     = res.n1y;
    assign o_new_second_x    = res.n2x;
    assign o_new_second_y    = res.n2y;
    assign o_first_accel_dx  = res.a1x;
    assign o_first_accel_dy  = res.a1y;
    assign o_second_accel_dx = res.a2x;
    assign o_second_accel_dy = res.a2y;
    assign o_overlapped      = res.ovl;
    assign o_coincident      = res.coin;

endmodule
`default_nettype wire
